FILE: sv/swq_pkg.sv
// Shared types and constants for the stack_with_queries block.
// No dependencies; imported by the top level and its checker.
package swq_pkg;

    localparam int DATA_W    = 32;
    localparam int SUM_W     = 40;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_INSPECT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_REV_LO,
        S_REV_HI,
        S_INSPECT,
        S_Q_ENDS,
        S_Q_MID,
        S_DONE
    } t_state;

endpackage

FILE: sv/stack_with_queries.sv
// Bounded LIFO stack of signed words with query results, held in one RAM
// with two registered read ports and one write port.
// Depends on swq_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word: an action
//   (push, pop, reverse, inspect) and a push value. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result word per input
//   word: status, popped value, entry count, top/bottom/middle entries, and
//   on inspect the sum, largest, smallest and palindrome flag.
//   A new word is accepted the cycle after the previous result enters the output
//   register; the RAM's single write port (reverse) and the per-entry read walk
//   (inspect) set the rate.
//   Top, bottom and middle are re-read from RAM after every action.
//   The output register holds its result while i_out_stall is high; the
//   next word is still accepted and worked on, and waits in its final state
//   until the output register frees up.
//   Reset (synchronous, active low) empties the stack and drops any pending
//   result. RAM contents are not cleared; only entries below the count are
//   ever read, and accesses are sequenced so no read overlaps a pending write.
module stack_with_queries #(
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_action,
    input  logic signed [swq_pkg::DATA_W-1:0]      i_push_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_status,
    output logic signed [swq_pkg::DATA_W-1:0]      o_popped_value,
    output logic [swq_pkg::CNT_OUT_W-1:0]          o_entry_count,
    output logic signed [swq_pkg::DATA_W-1:0]      o_top_value,
    output logic signed [swq_pkg::DATA_W-1:0]      o_bottom_value,
    output logic signed [swq_pkg::DATA_W-1:0]      o_middle_value,
    output logic signed [swq_pkg::SUM_W-1:0]       o_total,
    output logic signed [swq_pkg::DATA_W-1:0]      o_largest,
    output logic signed [swq_pkg::DATA_W-1:0]      o_smallest,
    output logic                                   o_is_palindrome
);
    import swq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // storage
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a, r_rd_b;

    // control
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;

    // work registers
    t_status                    r_status, n_status;
    logic signed [DATA_W-1:0]   r_popped, n_popped;
    logic signed [DATA_W-1:0]   r_top, n_top;
    logic signed [SUM_W-1:0]    r_total, n_total;
    logic signed [DATA_W-1:0]   r_max, n_max;
    logic signed [DATA_W-1:0]   r_min, n_min;
    logic                       r_pal, n_pal;
    logic                       r_first, n_first;
    logic                       r_hit, n_hit;
    logic [CW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_lo, n_lo;
    logic [AW-1:0]              r_hi, n_hi;

    // output register
    t_status                    r_o_status;
    logic signed [DATA_W-1:0]   r_o_popped, r_o_top, r_o_bottom, r_o_middle;
    logic signed [DATA_W-1:0]   r_o_max, r_o_min;
    logic signed [SUM_W-1:0]    r_o_total;
    logic [CW-1:0]              r_o_count;
    logic                       r_o_pal;

    // RAM access
    logic                w_wr_en, w_rd_en_a, w_rd_en_b, w_load;
    logic [AW-1:0]       w_wr_addr, w_rd_addr_a, w_rd_addr_b;
    logic [DATA_W-1:0]   w_wr_data;

    logic                       w_empty, w_full, w_more;
    logic [AW-1:0]              w_top_addr, w_mid_addr;
    logic signed [DATA_W-1:0]   w_val;

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_top_addr = w_empty ? '0 : AW'(r_count - CW'(1));
    assign w_mid_addr = w_empty ? '0 : AW'((r_count - CW'(1)) >> 1);
    // another pair to swap after (lo, hi)
    assign w_more     = (CW'(r_hi) > CW'(r_lo) + CW'(2));
    assign w_val      = $signed(r_rd_a);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid & i_out_stall;
        n_status    = r_status;
        n_popped    = r_popped;
        n_top       = r_top;
        n_total     = r_total;
        n_max       = r_max;
        n_min       = r_min;
        n_pal       = r_pal;
        n_first     = r_first;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = '0;
        w_rd_en_a   = 1'b0;
        w_rd_en_b   = 1'b0;
        w_rd_addr_a = '0;
        w_rd_addr_b = '0;
        w_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    n_total  = '0;
                    n_max    = '0;
                    n_min    = '0;
                    n_pal    = 1'b0;
                    n_state  = S_Q_ENDS;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = AW'(r_count);
                                w_wr_data = i_push_value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (w_empty) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                w_rd_en_a   = 1'b1;
                                w_rd_addr_a = w_top_addr;
                                n_state     = S_POP;
                            end
                        end
                        ACT_REVERSE: begin
                            n_lo = '0;
                            n_hi = w_top_addr;
                            if (r_count > CW'(1)) begin
                                w_rd_en_a   = 1'b1;
                                w_rd_en_b   = 1'b1;
                                w_rd_addr_a = '0;
                                w_rd_addr_b = w_top_addr;
                                n_state     = S_REV_LO;
                            end
                        end
                        ACT_INSPECT: begin
                            n_idx   = '0;
                            n_hit   = 1'b0;
                            n_first = 1'b1;
                            n_pal   = 1'b1;
                            n_state = S_INSPECT;
                        end
                        default: begin
                            n_state = S_Q_ENDS;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = $signed(r_rd_a);
                n_count  = r_count - CW'(1);
                n_state  = S_Q_ENDS;
            end
            S_REV_LO: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_lo;
                w_wr_data = r_rd_b;
                n_state   = S_REV_HI;
            end
            S_REV_HI: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_hi;
                w_wr_data = r_rd_a;
                if (w_more) begin
                    // next pair read never touches lo or hi being written
                    w_rd_en_a   = 1'b1;
                    w_rd_en_b   = 1'b1;
                    w_rd_addr_a = r_lo + AW'(1);
                    w_rd_addr_b = r_hi - AW'(1);
                    n_lo        = r_lo + AW'(1);
                    n_hi        = r_hi - AW'(1);
                    n_state     = S_REV_LO;
                end else begin
                    n_state = S_Q_ENDS;
                end
            end
            S_INSPECT: begin
                // read entry i and its mirror, fold them in the cycle after
                if (r_idx < r_count) begin
                    w_rd_en_a   = 1'b1;
                    w_rd_en_b   = 1'b1;
                    w_rd_addr_a = AW'(r_idx);
                    w_rd_addr_b = AW'(r_count - CW'(1) - r_idx);
                    n_idx       = r_idx + CW'(1);
                    n_hit       = 1'b1;
                end else begin
                    n_hit = 1'b0;
                end
                if (r_hit) begin
                    n_total = r_total + {{(SUM_W-DATA_W){w_val[DATA_W-1]}}, w_val};
                    if (r_first || w_val > r_max) begin
                        n_max = w_val;
                    end
                    if (r_first || w_val < r_min) begin
                        n_min = w_val;
                    end
                    n_first = 1'b0;
                    if (r_rd_a != r_rd_b) begin
                        n_pal = 1'b0;
                    end
                end
                if (!r_hit && r_idx == r_count) begin
                    n_state = S_Q_ENDS;
                end
            end
            S_Q_ENDS: begin
                if (!w_empty) begin
                    w_rd_en_a   = 1'b1;
                    w_rd_en_b   = 1'b1;
                    w_rd_addr_a = w_top_addr;
                    w_rd_addr_b = '0;
                end
                n_state = S_Q_MID;
            end
            S_Q_MID: begin
                n_top = $signed(r_rd_a);
                if (!w_empty) begin
                    w_rd_en_a   = 1'b1;
                    w_rd_addr_a = w_mid_addr;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en_a) begin
            r_rd_a <= r_mem[w_rd_addr_a];
        end
        if (w_rd_en_b) begin
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_popped <= n_popped;
        r_top    <= n_top;
        r_total  <= n_total;
        r_max    <= n_max;
        r_min    <= n_min;
        r_pal    <= n_pal;
        r_first  <= n_first;
        r_hit    <= n_hit;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_popped <= r_popped;
            r_o_count  <= r_count;
            r_o_top    <= w_empty ? '0 : r_top;
            r_o_bottom <= w_empty ? '0 : $signed(r_rd_b);
            r_o_middle <= w_empty ? '0 : $signed(r_rd_a);
            r_o_total  <= r_total;
            r_o_max    <= r_max;
            r_o_min    <= r_min;
            r_o_pal    <= r_pal;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_popped_value  = r_o_popped;
    assign o_entry_count   = CNT_OUT_W'(r_o_count);
    assign o_top_value     = r_o_top;
    assign o_bottom_value  = r_o_bottom;
    assign o_middle_value  = r_o_middle;
    assign o_total         = r_o_total;
    assign o_largest       = r_o_max;
    assign o_smallest      = r_o_min;
    assign o_is_palindrome = r_o_pal;

endmodule

FILE: sv/swq_check.sv
// Port-level checks for stack_with_queries, attached by bind.
// Depends on swq_pkg and the top level's ports.
module swq_check #(
    parameter int DEPTH = 8
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic [1:0]                             i_action,
    input logic signed [swq_pkg::DATA_W-1:0]      i_push_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic [1:0]                             o_status,
    input logic signed [swq_pkg::DATA_W-1:0]      o_popped_value,
    input logic [swq_pkg::CNT_OUT_W-1:0]          o_entry_count,
    input logic signed [swq_pkg::DATA_W-1:0]      o_top_value,
    input logic signed [swq_pkg::DATA_W-1:0]      o_bottom_value,
    input logic signed [swq_pkg::DATA_W-1:0]      o_middle_value,
    input logic signed [swq_pkg::SUM_W-1:0]       o_total,
    input logic signed [swq_pkg::DATA_W-1:0]      o_largest,
    input logic signed [swq_pkg::DATA_W-1:0]      o_smallest,
    input logic                                   o_is_palindrome
);
    import swq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_entry_count) && $stable(o_top_value))
        else $error("result word changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CNT_OUT_W'(DEPTH))
        else $error("entry count above depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OVERFLOW |-> o_entry_count == CNT_OUT_W'(DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_UNDERFLOW |->
            o_entry_count == '0 && o_popped_value == '0)
        else $error("underflow reported with entries or a popped word");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_count == '0 |->
            o_top_value == '0 && o_bottom_value == '0 && o_middle_value == '0)
        else $error("empty stack shows nonzero entries");

endmodule

bind stack_with_queries swq_check #(.DEPTH(DEPTH)) u_swq_check (.*);

FILE: sim/stack_with_queries_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stack_with_queries LIFO block.
// Depends on swq_pkg and stack_with_queries; runs a directed table, then random words.
module stack_with_queries_test;
    import swq_pkg::*;

    localparam int STACK_DEPTH  = 8;
    localparam int RANDOM_WORDS = 1250;
    localparam int DIR_ROWS     = 20;
    localparam int DRAIN_CYCLES = 32;
    localparam logic signed [DATA_W-1:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WMIN = 32'sh8000_0000;

    typedef struct packed {
        t_status               status;
        logic [DATA_W-1:0]     popped;
        logic [CNT_OUT_W-1:0]  count;
        logic [DATA_W-1:0]     top;
        logic [DATA_W-1:0]     bottom;
        logic [DATA_W-1:0]     middle;
        logic [SUM_W-1:0]      total;
        logic [DATA_W-1:0]     largest;
        logic [DATA_W-1:0]     smallest;
        logic                  palin;
    } t_stack_result;

    typedef struct packed {
        t_action            act;
        logic [DATA_W-1:0]  word;
        bit                 fixed;
        t_stack_result      res;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_action;
    logic signed [DATA_W-1:0]    i_push_value;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [1:0]                  o_status;
    logic signed [DATA_W-1:0]    o_popped_value;
    logic [CNT_OUT_W-1:0]        o_entry_count;
    logic signed [DATA_W-1:0]    o_top_value;
    logic signed [DATA_W-1:0]    o_bottom_value;
    logic signed [DATA_W-1:0]    o_middle_value;
    logic signed [SUM_W-1:0]     o_total;
    logic signed [DATA_W-1:0]    o_largest;
    logic signed [DATA_W-1:0]    o_smallest;
    logic                        o_is_palindrome;

    // Shadow stack of the predictor
    logic signed [DATA_W-1:0] stack_words [STACK_DEPTH];
    int                       stack_fill;

    t_stack_result expected_q [$];
    bit            drv_fixed;
    t_stack_result drv_fixed_res;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            words_sent;
    int            results_seen;
    int            overflow_hits;
    int            underflow_hits;
    int            palindrome_hits;
    int            errors;
    t_dir_row      dir_table [DIR_ROWS];

    stack_with_queries #(.DEPTH(STACK_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_push_value    (i_push_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_popped_value  (o_popped_value),
        .o_entry_count   (o_entry_count),
        .o_top_value     (o_top_value),
        .o_bottom_value  (o_bottom_value),
        .o_middle_value  (o_middle_value),
        .o_total         (o_total),
        .o_largest       (o_largest),
        .o_smallest      (o_smallest),
        .o_is_palindrome (o_is_palindrome)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Applies one action to the shadow stack and returns the result word it gives
    function automatic t_stack_result apply_action(t_action act,
                                                   logic signed [DATA_W-1:0] word);
        t_stack_result r;
        logic signed [DATA_W-1:0] tmp, mx, mn;
        longint acc;
        int lo, hi;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    stack_fill--;
                    r.popped = stack_words[stack_fill];
                end
            end
            ACT_REVERSE: begin
                lo = 0;
                hi = stack_fill - 1;
                while (lo < hi) begin
                    tmp = stack_words[lo];
                    stack_words[lo] = stack_words[hi];
                    stack_words[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: begin
                acc = 0;
                r.palin = 1'b1;
                if (stack_fill > 0) begin
                    mx = stack_words[0];
                    mn = stack_words[0];
                    for (int i = 0; i < stack_fill; i++) begin
                        acc += stack_words[i];
                        if (stack_words[i] > mx) mx = stack_words[i];
                        if (stack_words[i] < mn) mn = stack_words[i];
                        if (stack_words[i] != stack_words[stack_fill - 1 - i]) r.palin = 1'b0;
                    end
                    r.largest  = mx;
                    r.smallest = mn;
                end
                r.total = acc[SUM_W-1:0];
            end
        endcase
        r.count = stack_fill[CNT_OUT_W-1:0];
        if (stack_fill > 0) begin
            r.top    = stack_words[stack_fill - 1];
            r.bottom = stack_words[0];
            r.middle = stack_words[(stack_fill - 1) / 2];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_stack_result want;
        t_stack_result model_res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    results_seen++;
                    check_field("status", want.status, o_status);
                    check_field("popped_value", $signed(want.popped), o_popped_value);
                    check_field("entry_count", want.count, o_entry_count);
                    check_field("top_value", $signed(want.top), o_top_value);
                    check_field("bottom_value", $signed(want.bottom), o_bottom_value);
                    check_field("middle_value", $signed(want.middle), o_middle_value);
                    check_field("total", $signed(want.total), o_total);
                    check_field("largest", $signed(want.largest), o_largest);
                    check_field("smallest", $signed(want.smallest), o_smallest);
                    check_field("is_palindrome", want.palin, o_is_palindrome);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                model_res = apply_action(t_action'(i_action), i_push_value);
                want = drv_fixed ? drv_fixed_res : model_res;
                expected_q.push_back(want);
                if (want.status == ST_OVERFLOW) overflow_hits++;
                if (want.status == ST_UNDERFLOW) underflow_hits++;
                if (want.palin && want.count > 1) palindrome_hits++;
            end
        end
    end

    // Offers one word, with random idle cycles ahead of it, and waits until it is taken
    task automatic send_word(t_action act, logic signed [DATA_W-1:0] word,
                             bit fixed = 1'b0, t_stack_result fixed_res = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_push_value  <= word;
        drv_fixed     <= fixed;
        drv_fixed_res <= fixed_res;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return WMAX;
            1:       return WMIN;
            2:       return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic signed [DATA_W-1:0] half [STACK_DEPTH];
        int len, bad_pos, phase_end;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_PUSH;
        i_push_value   = '0;
        i_out_stall    = 1'b0;
        drv_fixed      = 1'b0;
        drv_fixed_res  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stack_fill     = 0;
        words_sent     = 0;
        results_seen   = 0;
        overflow_hits  = 0;
        underflow_hits = 0;
        palindrome_hits = 0;
        errors         = 0;

        // Empty-stack cases, one-entry reverse, word extremes, sum of -1
        dir_table[0]  = '{ACT_POP, 32'd0, 1'b1, '{ST_UNDERFLOW, 32'd0, 7'd0, 32'd0, 32'd0,
                          32'd0, 40'd0, 32'd0, 32'd0, 1'b0}};
        dir_table[1]  = '{ACT_INSPECT, 32'd0, 1'b1, '{ST_OK, 32'd0, 7'd0, 32'd0, 32'd0,
                          32'd0, 40'd0, 32'd0, 32'd0, 1'b1}};
        dir_table[2]  = '{ACT_REVERSE, 32'd0, 1'b1, '{ST_OK, 32'd0, 7'd0, 32'd0, 32'd0,
                          32'd0, 40'd0, 32'd0, 32'd0, 1'b0}};
        dir_table[3]  = '{ACT_PUSH, WMAX, 1'b1, '{ST_OK, 32'd0, 7'd1, WMAX, WMAX,
                          WMAX, 40'd0, 32'd0, 32'd0, 1'b0}};
        dir_table[4]  = '{ACT_REVERSE, 32'd0, 1'b1, '{ST_OK, 32'd0, 7'd1, WMAX, WMAX,
                          WMAX, 40'd0, 32'd0, 32'd0, 1'b0}};
        dir_table[5]  = '{ACT_PUSH, WMIN, 1'b1, '{ST_OK, 32'd0, 7'd2, WMIN, WMAX,
                          WMAX, 40'd0, 32'd0, 32'd0, 1'b0}};
        dir_table[6]  = '{ACT_INSPECT, 32'd0, 1'b1, '{ST_OK, 32'd0, 7'd2, WMIN, WMAX,
                          WMAX, 40'hFF_FFFF_FFFF, WMAX, WMIN, 1'b0}};
        dir_table[7]  = '{ACT_REVERSE, 32'd0, 1'b0, '0};
        dir_table[8]  = '{ACT_PUSH, 32'hFFFF_FFFF, 1'b0, '0};
        dir_table[9]  = '{ACT_PUSH, 32'd0, 1'b0, '0};
        dir_table[10] = '{ACT_PUSH, 32'd1, 1'b0, '0};
        dir_table[11] = '{ACT_PUSH, 32'h5555_5555, 1'b0, '0};
        dir_table[12] = '{ACT_PUSH, 32'hAAAA_AAAA, 1'b0, '0};
        dir_table[13] = '{ACT_PUSH, 32'd7, 1'b0, '0};
        dir_table[14] = '{ACT_PUSH, 32'd3, 1'b0, '0};
        dir_table[15] = '{ACT_INSPECT, 32'd0, 1'b0, '0};
        dir_table[16] = '{ACT_REVERSE, 32'd0, 1'b0, '0};
        dir_table[17] = '{ACT_INSPECT, 32'd0, 1'b0, '0};
        dir_table[18] = '{ACT_POP, 32'd0, 1'b0, '0};
        dir_table[19] = '{ACT_POP, 32'd0, 1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r])
            send_word(dir_table[r].act, dir_table[r].word, dir_table[r].fixed, dir_table[r].res);

        // Phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            phase_end = DIR_ROWS + (phase + 1) * RANDOM_WORDS / 4;
            while (words_sent < phase_end) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        repeat (8) send_word(t_action'($urandom_range(3)), pick_word());
                    end
                    4, 5: begin
                        // fill past full, then query around a reverse
                        repeat ($urandom_range(9, 11)) send_word(ACT_PUSH, pick_word());
                        send_word(ACT_INSPECT, pick_word());
                        send_word(ACT_REVERSE, pick_word());
                        send_word(ACT_INSPECT, pick_word());
                    end
                    6, 7: begin
                        repeat ($urandom_range(9, 11)) send_word(ACT_POP, pick_word());
                    end
                    default: begin
                        // drain, then build a mirrored stack, sometimes with one bad word
                        repeat (STACK_DEPTH + 1) send_word(ACT_POP, pick_word());
                        len = $urandom_range(1, STACK_DEPTH);
                        bad_pos = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : -1;
                        for (int i = 0; i < (len + 1) / 2; i++) half[i] = pick_word();
                        for (int i = 0; i < len; i++)
                            send_word(ACT_PUSH, (i == bad_pos) ? pick_word()
                                                 : half[(i < len - 1 - i) ? i : len - 1 - i]);
                        send_word(ACT_INSPECT, pick_word());
                        send_word(ACT_REVERSE, pick_word());
                        send_word(ACT_INSPECT, pick_word());
                    end
                endcase
            end
        end
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d from the directed table), checked %0d results.",
                 words_sent, DIR_ROWS, results_seen);
        $display("Hit %0d overflows, %0d underflows, %0d multi-entry palindromes.",
                 overflow_hits, underflow_hits, palindrome_hits);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
